>>> hw/rtl/rtbr_pkg.sv
`default_nettype none
package rtbr_pkg;

	localparam int SUM_W             = 32;
	localparam int CNT_W             = 16;
	localparam int BYTE_W            = 8;
	localparam int LEVELS            = 1 << BYTE_W;
	localparam int THR_W             = 32;
	localparam int BIG_W             = 384;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int POW_DEN           = 53805;
	localparam int POW_STEP          = 200;
	localparam int POW_BASE          = 2705;
	localparam int LIN_LAST_LEVEL    = 10;

	localparam logic [BYTE_W-1:0] ALPHA_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] BLACK_BYTE = 8'h00;

	typedef logic [LEVELS-1:0][THR_W-1:0] thr_t;

	function automatic logic reaches(longint unsigned q, int k, int f,
	                                 logic [BIG_W-1:0] pden);
		logic [BIG_W-1:0]  lhs;
		logic [BIG_W-1:0]  rhs;
		longint unsigned   one;
		logic              res;
		one = longint'(1) << f;
		if (q >= one) begin
			res = 1'b1;
		end else if (q * 64'd10000000 <= (64'd31308 << f)) begin
			res = ((q * 64'd32946 + 64'd5 * one) >= (64'(k) * 64'd10 * one));
		end else if (k <= LIN_LAST_LEVEL) begin
			res = 1'b1;
		end else begin
			lhs = BIG_W'(1);
			for (int i = 0; i < 5; i++)
				lhs = lhs * BIG_W'(q);
			lhs = lhs * pden;
			rhs = BIG_W'(1);
			for (int i = 0; i < 12; i++)
				rhs = rhs * BIG_W'(POW_STEP * k + POW_BASE);
			rhs = rhs << (5 * f);
			res = (lhs >= rhs);
		end
		return res;
	endfunction

	// smallest quotient that reaches each output level
	function automatic thr_t thresholds(int f);
		thr_t              t;
		logic [BIG_W-1:0]  pden;
		longint unsigned   lo;
		longint unsigned   hi;
		longint unsigned   mid;
		pden = BIG_W'(1);
		for (int i = 0; i < 12; i++)
			pden = pden * BIG_W'(POW_DEN);
		t = '0;
		for (int k = 1; k < LEVELS; k++) begin
			lo = 0;
			hi = longint'(1) << f;
			for (int s = 0; s <= THR_W; s++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					if (reaches(mid, k, f, pden))
						hi = mid;
					else
						lo = mid + 1;
				end
			end
			t[k] = THR_W'(lo);
		end
		return t;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rtbr_div.sv
`default_nettype none
module rtbr_div (
	input  wire logic                       clk,
	input  wire logic [rtbr_pkg::SUM_W-1:0] dividend,
	input  wire logic [rtbr_pkg::CNT_W-1:0] divisor,
	output logic      [rtbr_pkg::SUM_W-1:0] quotient
);

	localparam int SW = rtbr_pkg::SUM_W;
	localparam int CW = rtbr_pkg::CNT_W;

	logic [SW-1:0] nq_s  [0:SW];
	logic [CW-1:0] rem_s [0:SW];
	logic [CW-1:0] den_s [0:SW];

	always_ff @(posedge clk) begin
		nq_s[0]  <= dividend;
		rem_s[0] <= '0;
		den_s[0] <= divisor;
	end

	for (genvar j = 0; j < SW; j++) begin : g_step
		logic [CW:0] trial;
		logic [CW:0] diff;
		logic        ge;
		always_comb begin
			trial = {rem_s[j], nq_s[j][SW-1]};
			diff  = trial - {1'b0, den_s[j]};
			ge    = (trial >= {1'b0, den_s[j]});
		end
		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? diff[CW-1:0] : trial[CW-1:0];
			nq_s[j+1]  <= {nq_s[j][SW-2:0], ge};
			den_s[j+1] <= den_s[j];
		end
	end

	assign quotient = nq_s[SW];

endmodule
`default_nettype wire

>>> hw/rtl/rtbr_encode.sv
`default_nettype none
module rtbr_encode #(
	parameter int FRACTION_BITS = rtbr_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic [rtbr_pkg::SUM_W-1:0]  q,
	output logic      [rtbr_pkg::BYTE_W-1:0] level
);

	localparam int SW = rtbr_pkg::SUM_W;
	localparam int BW = rtbr_pkg::BYTE_W;
	localparam rtbr_pkg::thr_t THR = rtbr_pkg::thresholds(FRACTION_BITS);

	logic [SW-1:0] q_s   [1:BW];
	logic [BW-1:0] acc_s [1:BW];

	for (genvar i = 0; i < BW; i++) begin : g_bit
		logic [SW-1:0] src_q;
		logic [BW-1:0] src_acc;
		logic [BW-1:0] cand;
		logic          hit;
		if (i == 0) begin : g_first
			assign src_q   = q;
			assign src_acc = '0;
		end else begin : g_next
			assign src_q   = q_s[i];
			assign src_acc = acc_s[i];
		end
		always_comb begin
			cand = src_acc | (BW'(1) << (BW - 1 - i));
			hit  = (src_q >= SW'(THR[cand]));
		end
		always_ff @(posedge clk) begin
			q_s[i+1]   <= src_q;
			acc_s[i+1] <= hit ? cand : src_acc;
		end
	end

	assign level = acc_s[BW];

endmodule
`default_nettype wire

>>> hw/rtl/radiance_to_srgb_byte_resolve.sv
// channel   dir  signals                                           handshake
// request   in   red_sum green_sum blue_sum sample_count           start, busy
// result    out  alpha_byte blue_byte green_byte red_byte          done strobe
//
// One request per cycle; busy stays low.
// Pipeline: the bit-serial divider (one quotient bit a stage), then the level search over the
// threshold table, then the output register.
// Reset clears the valid pipeline and done; payload registers are not reset.
// Results cannot be stalled: done marks each result for one cycle.
`default_nettype none
module radiance_to_srgb_byte_resolve #(
	parameter int FRACTION_BITS = rtbr_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [rtbr_pkg::SUM_W-1:0]  red_sum,
	input  wire logic [rtbr_pkg::SUM_W-1:0]  green_sum,
	input  wire logic [rtbr_pkg::SUM_W-1:0]  blue_sum,
	input  wire logic [rtbr_pkg::CNT_W-1:0]  sample_count,
	output logic                             done,
	output logic      [rtbr_pkg::BYTE_W-1:0] alpha_byte,
	output logic      [rtbr_pkg::BYTE_W-1:0] blue_byte,
	output logic      [rtbr_pkg::BYTE_W-1:0] green_byte,
	output logic      [rtbr_pkg::BYTE_W-1:0] red_byte
);

	localparam int SW   = rtbr_pkg::SUM_W;
	localparam int BW   = rtbr_pkg::BYTE_W;
	localparam int PIPE = SW + 1 + BW;
	localparam int LAT  = PIPE + 1;

	logic            accept;
	logic [PIPE-1:0] vld_q;
	logic [PIPE-1:0] zero_q;
	logic [SW-1:0]   quo [3];
	logic [BW-1:0]   lvl [3];
	logic [SW-1:0]   sums [3];
	logic            done_q;
	logic [BW-1:0]   red_q;
	logic [BW-1:0]   green_q;
	logic [BW-1:0]   blue_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign sums[0] = red_sum;
	assign sums[1] = green_sum;
	assign sums[2] = blue_sum;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		rtbr_div u_div (
			.clk      (clk),
			.dividend (sums[c]),
			.divisor  (sample_count),
			.quotient (quo[c])
		);
		rtbr_encode #(
			.FRACTION_BITS (FRACTION_BITS)
		) u_enc (
			.clk   (clk),
			.q     (quo[c]),
			.level (lvl[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[PIPE-2:0], accept};
			done_q <= vld_q[PIPE-1];
		end
	end

	always_ff @(posedge clk) begin
		zero_q  <= {zero_q[PIPE-2:0], (sample_count == '0)};
		red_q   <= zero_q[PIPE-1] ? rtbr_pkg::BLACK_BYTE : lvl[0];
		green_q <= zero_q[PIPE-1] ? rtbr_pkg::BLACK_BYTE : lvl[1];
		blue_q  <= zero_q[PIPE-1] ? rtbr_pkg::BLACK_BYTE : lvl[2];
	end

	assign done       = done_q;
	assign alpha_byte = rtbr_pkg::ALPHA_BYTE;
	assign red_byte   = red_q;
	assign green_byte = green_q;
	assign blue_byte  = blue_q;

	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without request");

	a_zero_count_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(sample_count == '0, LAT))
		|-> (red_byte == '0 && green_byte == '0 && blue_byte == '0))
		else $error("zero count not black");

	a_full_sum_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(sample_count == 16'd1 && red_sum == '1, LAT))
		|-> (red_byte == '1))
		else $error("saturation lost");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = rtbr_pkg::FRACTION_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [rtbr_pkg::SUM_W-1:0] red;
		logic [rtbr_pkg::SUM_W-1:0] green;
		logic [rtbr_pkg::SUM_W-1:0] blue;
		logic [rtbr_pkg::CNT_W-1:0] cnt;
	} pixel_t;

	typedef struct packed {
		logic [rtbr_pkg::BYTE_W-1:0] a;
		logic [rtbr_pkg::BYTE_W-1:0] b;
		logic [rtbr_pkg::BYTE_W-1:0] g;
		logic [rtbr_pkg::BYTE_W-1:0] r;
	} rgba_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [rtbr_pkg::SUM_W-1:0] red_sum = '0;
	logic [rtbr_pkg::SUM_W-1:0] green_sum = '0;
	logic [rtbr_pkg::SUM_W-1:0] blue_sum = '0;
	logic [rtbr_pkg::CNT_W-1:0] sample_count = '0;
	logic busy;
	logic done;
	logic [rtbr_pkg::BYTE_W-1:0] alpha_byte;
	logic [rtbr_pkg::BYTE_W-1:0] blue_byte;
	logic [rtbr_pkg::BYTE_W-1:0] green_byte;
	logic [rtbr_pkg::BYTE_W-1:0] red_byte;

	rgba_t pending_rgba[$];
	int errors = 0;
	int pixels_sent = 0;
	int pixels_resolved = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int zero_cnt_seen = 0;
	int sat_seen = 0;

	always #6 clk = ~clk;

	radiance_to_srgb_byte_resolve dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red_sum(red_sum), .green_sum(green_sum), .blue_sum(blue_sum),
		.sample_count(sample_count), .done(done), .alpha_byte(alpha_byte),
		.blue_byte(blue_byte), .green_byte(green_byte), .red_byte(red_byte)
	);

	function automatic logic [rtbr_pkg::BYTE_W-1:0] srgb_level(
	                                        logic [rtbr_pkg::SUM_W-1:0] sum,
	                                        logic [rtbr_pkg::CNT_W-1:0] cnt);
		longint unsigned q;
		longint unsigned one;
		logic [383:0] lhs;
		logic [383:0] rhs;
		logic [383:0] pden;
		int lo;
		int hi;
		int mid;
		one = 64'd1 << FB;
		if (cnt == 0)
			return rtbr_pkg::BLACK_BYTE;
		q = longint'(sum) / longint'(cnt);
		if (q >= one)
			return 8'd255;
		if (q * 64'd10000000 <= (64'd31308 << FB))
			return rtbr_pkg::BYTE_W'((q * 64'd32946 + 64'd5 * one) / (64'd10 * one));
		pden = 384'd1;
		for (int i = 0; i < 12; i++)
			pden = pden * 384'd53805;
		lhs = 384'd1;
		for (int i = 0; i < 5; i++)
			lhs = lhs * 384'(q);
		lhs = lhs * pden;
		lo = 10;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			rhs = 384'd1;
			for (int i = 0; i < 12; i++)
				rhs = rhs * 384'(200 * mid + 2705);
			rhs = rhs << (5 * FB);
			if (lhs >= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return rtbr_pkg::BYTE_W'(lo);
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// predict each accepted request
	always @(posedge clk) begin
		rgba_t e;
		if (arst_n && start && !busy) begin
			e.a = rtbr_pkg::ALPHA_BYTE;
			e.r = srgb_level(red_sum, sample_count);
			e.g = srgb_level(green_sum, sample_count);
			e.b = srgb_level(blue_sum, sample_count);
			pending_rgba.push_back(e);
			pixels_sent++;
			if (sample_count == 0)
				zero_cnt_seen++;
		end
	end

	always @(posedge clk) begin
		rgba_t e;
		if (arst_n && done) begin
			pixels_resolved++;
			if (pending_rgba.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = pending_rgba.pop_front();
				if (alpha_byte !== e.a) report("alpha_byte", alpha_byte, e.a);
				if (red_byte !== e.r) report("red_byte", red_byte, e.r);
				if (green_byte !== e.g) report("green_byte", green_byte, e.g);
				if (blue_byte !== e.b) report("blue_byte", blue_byte, e.b);
				if (e.r == 8'd255 || e.g == 8'd255 || e.b == 8'd255)
					sat_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding", pending_rgba.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_pixel(pixel_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		start <= 1'b1;
		red_sum <= p.red;
		green_sum <= p.green;
		blue_sum <= p.blue;
		sample_count <= p.cnt;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [rtbr_pkg::SUM_W-1:0] sum_for(
	                                        logic [rtbr_pkg::CNT_W-1:0] cnt, int q);
		return rtbr_pkg::SUM_W'(longint'(cnt) * q + $urandom_range(0, cnt - 1));
	endfunction

	task automatic test_zero_count();
		send_pixel('{32'hFFFFFFFF, 32'h0, 32'h00010000, 16'h0});
		send_pixel('{32'h0, 32'hFFFFFFFF, 32'h12345678, 16'h0});
	endtask

	task automatic test_extremes();
		send_pixel('{32'h0, 32'h1, 32'hFFFFFFFF, 16'h1});
		send_pixel('{32'h0000FFFF, 32'h00010000, 32'h00010001, 16'h1});
		send_pixel('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF});
		send_pixel('{32'hFFFEFFFF, 32'hFFFF0000, 32'h0000FFFF, 16'hFFFF});
		send_pixel('{32'h80000000, 32'h7FFFFFFF, 32'h55555555, 16'h8000});
		send_pixel('{32'hAAAAAAAA, 32'h5555AAAA, 32'h00000001, 16'h7FFF});
	endtask

	// straddle the switch from the linear to the power segment
	task automatic test_segment_edge();
		for (int q = 203; q <= 209; q++)
			send_pixel('{rtbr_pkg::SUM_W'(q), rtbr_pkg::SUM_W'(q * 3),
			             rtbr_pkg::SUM_W'(q * 3 + 2), 16'd1});
		send_pixel('{32'd820, 32'd823, 32'd2, 16'd4});
		send_pixel('{32'd1, 32'd2, 32'd10, 16'd1});
		send_pixel('{32'd65534, 32'd65000, 32'd60000, 16'd1});
	endtask

	task automatic test_random(int n);
		pixel_t p;
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				p.cnt = ($urandom_range(0, 3) == 0)
				        ? rtbr_pkg::CNT_W'($urandom_range(1, 65535))
				        : rtbr_pkg::CNT_W'($urandom_range(1, 64));
				p.red = sum_for(p.cnt, $urandom_range(0, 65535));
				p.green = sum_for(p.cnt, $urandom_range(0, 65535));
				p.blue = sum_for(p.cnt, $urandom_range(0, 65535));
			end else if (kind < 8) begin
				p.cnt = rtbr_pkg::CNT_W'($urandom_range(1, 16));
				p.red = sum_for(p.cnt, $urandom_range(0, 400));
				p.green = sum_for(p.cnt, $urandom_range(150, 260));
				p.blue = sum_for(p.cnt, $urandom_range(0, 2000));
			end else begin
				p.cnt = ($urandom_range(0, 15) == 0) ? '0 : rtbr_pkg::CNT_W'($urandom);
				p.red = $urandom;
				p.green = $urandom;
				p.blue = $urandom;
			end
			send_pixel(p);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_count();
		test_extremes();
		test_segment_edge();
		test_random(1150);
		start <= 1'b0;
		while (pending_rgba.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rgba.size() != 0)
			report("results left over", pending_rgba.size(), 0);
		$display("Resolved %0d of %0d pixels; %0d with zero count, %0d with a saturated channel",
		         pixels_resolved, pixels_sent, zero_cnt_seen, sat_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
